/* sv/mp2ds_pkg.sv */
`timescale 1ns / 1ps
package mp2ds_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_COLS       = 256;
  localparam int MAX_COMPONENTS = 16;
  localparam int MAX_WINDOW     = 16;
  localparam int MAX_ROWS       = 1024;
  localparam int STORE_DEPTH    = MAX_COLS * MAX_COMPONENTS;
  localparam int IDX_W          = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROWS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COLS     = 3'd5;

  // configuration, already clamped to legal ranges
  typedef struct packed {
    logic [15:0] image_count;
    logic [10:0] image_rows;
    logic [8:0]  image_cols;
    logic [4:0]  component_count;
    logic [4:0]  window_rows;
    logic [4:0]  window_cols;
  } cfg_t;

  // one classified sample, handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [IDX_W-1:0]              idx;
    logic                          first;
    logic                          last;
    logic                          last_of_image;
    logic                          last_of_batch;
  } entry_t;

endpackage

/* sv/max_pool_2d_stream.sv */
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tdata[15:0] sample (signed Q8.8)
// m_axis    out        tdata[15:0] max_value, tlast last_of_image, tuser last_of_batch
// cfg       in         cfg_we_i, cfg_idx_i (register 0..5), cfg_data_i
//
// One sample is taken per cycle while the queue is not full; the back end reads
// and writes the running-maximum store in the same cycle.
// A result's tvalid rises once its last sample has passed the queue slot, the store
// read stage and the output register.
// After reset the store holds nothing valid; a window's first sample writes its entry.
// A 4-entry queue parts the counters from the store, so a stalled output
// holds the store pipe while input keeps flowing until the queue fills.
module max_pool_2d_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] max_value
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] last_of_batch
  input  logic        cfg_we_i,
  input  logic [mp2ds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mp2ds_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mp2ds_pkg::*;

  cfg_t   cfg_q;
  logic   accept, push, q_full, q_pop, q_valid;
  entry_t push_entry, q_head;

  // clamp a register value to 1..hi on write, so the datapath sees legal values
  function automatic logic [10:0] clamp11(input logic [10:0] v, input logic [10:0] hi);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_count     <= 16'd1;
      cfg_q.image_rows      <= 11'd1;
      cfg_q.image_cols      <= 9'd1;
      cfg_q.component_count <= 5'd1;
      cfg_q.window_rows     <= 5'd1;
      cfg_q.window_cols     <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_COUNT: begin
          cfg_q.image_count <= (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;
        end
        CFG_IMAGE_ROWS: begin
          cfg_q.image_rows <= clamp11(cfg_data_i[10:0], 11'(MAX_ROWS));
        end
        CFG_IMAGE_COLS: begin
          cfg_q.image_cols <= 9'(clamp11({2'b0, cfg_data_i[8:0]}, 11'(MAX_COLS)));
        end
        CFG_COMPONENT_COUNT: begin
          cfg_q.component_count <=
            5'(clamp11({6'b0, cfg_data_i[4:0]}, 11'(MAX_COMPONENTS)));
        end
        CFG_WINDOW_ROWS: begin
          cfg_q.window_rows <= 5'(clamp11({6'b0, cfg_data_i[4:0]}, 11'(MAX_WINDOW)));
        end
        CFG_WINDOW_COLS: begin
          cfg_q.window_cols <= 5'(clamp11({6'b0, cfg_data_i[4:0]}, 11'(MAX_WINDOW)));
        end
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // take a sample whenever the queue has room
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mp2ds_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .sample_i (s_axis_tdata),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  mp2ds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  mp2ds_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_value_o      (m_axis_tdata),
    .out_last_image_o (m_axis_tlast),
    .out_last_batch_o (m_axis_tuser)
  );

endmodule

/* sv/mp2ds_front.sv */
`timescale 1ns / 1ps
module mp2ds_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mp2ds_pkg::cfg_t     cfg_i,
  input  logic                accept_i,
  input  logic [15:0]         sample_i,
  output logic                push_o,
  output mp2ds_pkg::entry_t   entry_o
);
  import mp2ds_pkg::*;

  logic [9:0]  row_pos_q, row_pos_d;
  logic [7:0]  col_pos_q, col_pos_d;
  logic [3:0]  comp_pos_q, comp_pos_d;
  logic [3:0]  row_in_win_q, row_in_win_d;
  logic [3:0]  col_in_win_q, col_in_win_d;
  logic [15:0] image_pos_q, image_pos_d;
  logic [10:0] out_row_q, out_row_d;
  logic [8:0]  out_col_q, out_col_d;

  logic [16:0] row_end;
  logic [14:0] col_end;
  logic        row_ok, col_ok, comp_ok, row_final, col_final;
  logic [12:0] idx_full;
  logic        comp_wrap, ciw_wrap, col_wrap, riw_wrap, row_wrap, img_wrap;

  // window end positions in rows and columns for the current output cell
  assign row_end   = (17'(out_row_q) + 17'd1) * 17'(cfg_i.window_rows);
  assign col_end   = (15'(out_col_q) + 15'd1) * 15'(cfg_i.window_cols);
  assign row_ok    = row_end <= 17'(cfg_i.image_rows);
  assign col_ok    = col_end <= 15'(cfg_i.image_cols);
  assign comp_ok   = {1'b0, comp_pos_q} < cfg_i.component_count;
  assign row_final = row_ok && (row_end + 17'(cfg_i.window_rows) > 17'(cfg_i.image_rows));
  assign col_final = col_ok && (col_end + 15'(cfg_i.window_cols) > 15'(cfg_i.image_cols));
  assign idx_full  = 13'(out_col_q[7:0]) * 13'(cfg_i.component_count) + 13'(comp_pos_q);

  assign push_o                = accept_i && row_ok && col_ok && comp_ok;
  assign entry_o.sample        = sample_i;
  assign entry_o.idx           = idx_full[IDX_W-1:0];
  assign entry_o.first         = (row_in_win_q == 4'd0) && (col_in_win_q == 4'd0);
  assign entry_o.last          = ({1'b0, row_in_win_q} == cfg_i.window_rows - 5'd1) &&
                                 ({1'b0, col_in_win_q} == cfg_i.window_cols - 5'd1);
  assign entry_o.last_of_image = row_final && col_final &&
                                 ({1'b0, comp_pos_q} == cfg_i.component_count - 5'd1);
  assign entry_o.last_of_batch = entry_o.last_of_image &&
                                 (image_pos_q == cfg_i.image_count - 16'd1);

  assign comp_wrap = {1'b0, comp_pos_q} + 5'd1 >= cfg_i.component_count;
  assign ciw_wrap  = {1'b0, col_in_win_q} + 5'd1 >= cfg_i.window_cols;
  assign col_wrap  = {1'b0, col_pos_q} + 9'd1 >= cfg_i.image_cols;
  assign riw_wrap  = {1'b0, row_in_win_q} + 5'd1 >= cfg_i.window_rows;
  assign row_wrap  = {1'b0, row_pos_q} + 11'd1 >= cfg_i.image_rows;
  assign img_wrap  = {1'b0, image_pos_q} + 17'd1 >= {1'b0, cfg_i.image_count};

  // advance the position counters by one sample
  always_comb begin
    row_pos_d    = row_pos_q;
    col_pos_d    = col_pos_q;
    comp_pos_d   = comp_pos_q;
    row_in_win_d = row_in_win_q;
    col_in_win_d = col_in_win_q;
    image_pos_d  = image_pos_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    if (comp_wrap) begin
      comp_pos_d = 4'd0;
      if (ciw_wrap) begin
        col_in_win_d = 4'd0;
        out_col_d    = out_col_q + 9'd1;
      end else begin
        col_in_win_d = col_in_win_q + 4'd1;
      end
      if (col_wrap) begin
        col_pos_d    = 8'd0;
        col_in_win_d = 4'd0;
        out_col_d    = 9'd0;
        if (riw_wrap) begin
          row_in_win_d = 4'd0;
          out_row_d    = out_row_q + 11'd1;
        end else begin
          row_in_win_d = row_in_win_q + 4'd1;
        end
        if (row_wrap) begin
          row_pos_d    = 10'd0;
          row_in_win_d = 4'd0;
          out_row_d    = 11'd0;
          image_pos_d  = img_wrap ? 16'd0 : image_pos_q + 16'd1;
        end else begin
          row_pos_d = row_pos_q + 10'd1;
        end
      end else begin
        col_pos_d = col_pos_q + 8'd1;
      end
    end else begin
      comp_pos_d = comp_pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q    <= '0;
      col_pos_q    <= '0;
      comp_pos_q   <= '0;
      row_in_win_q <= '0;
      col_in_win_q <= '0;
      image_pos_q  <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
    end else if (accept_i) begin
      row_pos_q    <= row_pos_d;
      col_pos_q    <= col_pos_d;
      comp_pos_q   <= comp_pos_d;
      row_in_win_q <= row_in_win_d;
      col_in_win_q <= col_in_win_d;
      image_pos_q  <= image_pos_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
    end
  end

endmodule

/* sv/mp2ds_queue.sv */
`timescale 1ns / 1ps
module mp2ds_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mp2ds_pkg::entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output mp2ds_pkg::entry_t head_o
);
  import mp2ds_pkg::*;

  entry_t            slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("push into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count past depth");
`endif

endmodule

/* sv/mp2ds_back.sv */
`timescale 1ns / 1ps
module mp2ds_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mp2ds_pkg::entry_t q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       out_value_o,
  output logic              out_last_image_o,
  output logic              out_last_batch_o
);
  import mp2ds_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem_q [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [SAMPLE_BITS-1:0] fwd_val_q;
  logic                          fwd_hit_q;
  logic                          b_valid_q;
  entry_t                        b_q;
  logic signed [SAMPLE_BITS-1:0] cur, upd;
  logic                          b_adv;

  logic                          out_valid_q;
  logic [15:0]                   out_value_q;
  logic                          out_last_image_q, out_last_batch_q;

  // the previous item may have written this entry too late for the read
  assign cur     = fwd_hit_q ? fwd_val_q : rd_q;
  assign upd     = (b_q.first || b_q.sample > cur) ? b_q.sample : cur;
  assign b_adv   = b_valid_q && (!b_q.last || !out_valid_q || out_ready_i);
  assign q_pop_o = q_valid_i && (!b_valid_q || b_adv);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) rd_q <= mem_q[q_head_i.idx];
    if (b_adv)   mem_q[b_q.idx] <= upd;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_q       <= q_head_i;
      fwd_val_q <= upd;
    end
    if (b_adv && b_q.last) begin
      out_value_q      <= upd;
      out_last_image_q <= b_q.last_of_image;
      out_last_batch_q <= b_q.last_of_batch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        b_valid_q <= 1'b1;
        fwd_hit_q <= b_adv && (q_head_i.idx == b_q.idx);
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
        fwd_hit_q <= 1'b0;
      end
      if (b_adv && b_q.last) out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_value_o      = out_value_q;
  assign out_last_image_o = out_last_image_q;
  assign out_last_batch_o = out_last_batch_q;

`ifndef SYNTHESIS
  a_fwd_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> b_valid_q)
    else $error("forward flag set with empty stage");
  a_result_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv && b_q.last |=> out_valid_q)
    else $error("window result not registered");
  a_batch_implies_image : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_batch_q |-> out_last_image_q)
    else $error("end of batch without end of image");
`endif

endmodule

/* tb/sv/max_pool_2d_stream_test.sv */
`timescale 1ns / 1ps
module max_pool_2d_stream_test;
  import mp2ds_pkg::*;

  // Unmapped register indexes: writes there must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  // The block's pipe is 2 deep behind a 4-entry queue; give it a margin.
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 300;
  localparam int IDLE_PERCENT  = 27;

  typedef struct packed {
    logic [15:0] max_value;
    logic        last_of_image;
    logic        last_of_batch;
  } pooled_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [15:0] sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] max_value
  logic        m_axis_tlast;
  logic        m_axis_tuser;         // [0] last_of_batch
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  max_pool_2d_stream dut (.*);

  always #10 clk_i = ~clk_i;

  // Pending input samples and pooled maxima still owed by the block.
  logic [15:0] sample_q[$];
  pooled_t     pooled_q[$];

  bit          steady;        // suppress all idling on both sides
  int unsigned failures;

  // ---------------------------------------------------------------------------
  // Pooling predictor: register copies as written (masked to register width),
  // position counters and the running-maximum store.
  // ---------------------------------------------------------------------------
  int unsigned reg_shadow [6];
  int unsigned row_pos, col_pos, comp_pos, row_in_win, col_in_win;
  int unsigned img_pos, out_row, out_col;
  logic signed [SAMPLE_BITS-1:0] window_max [STORE_DEPTH];

  function automatic int unsigned reg_mask(logic [CFG_IDX_W-1:0] idx);
    case (idx)
      CFG_IMAGE_COUNT: return 16'hFFFF;
      CFG_IMAGE_ROWS:  return 11'h7FF;
      CFG_IMAGE_COLS:  return 9'h1FF;
      default:         return 5'h1F;
    endcase
  endfunction

  // Zero acts as one; anything above the bound acts as the bound.
  function automatic int unsigned eff_reg(logic [CFG_IDX_W-1:0] idx, int unsigned hi);
    int unsigned v;
    v = reg_shadow[idx];
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void pool_sample(logic signed [SAMPLE_BITS-1:0] s);
    int unsigned nimg, rows, cols, comps, wr, wc, orows, ocols, idx;
    logic signed [SAMPLE_BITS-1:0] m;
    pooled_t r;
    nimg  = eff_reg(CFG_IMAGE_COUNT, 65535);
    rows  = eff_reg(CFG_IMAGE_ROWS, MAX_ROWS);
    cols  = eff_reg(CFG_IMAGE_COLS, MAX_COLS);
    comps = eff_reg(CFG_COMPONENT_COUNT, MAX_COMPONENTS);
    wr    = eff_reg(CFG_WINDOW_ROWS, MAX_WINDOW);
    wc    = eff_reg(CFG_WINDOW_COLS, MAX_WINDOW);
    orows = rows / wr;
    ocols = cols / wc;

    // Only samples inside a whole window and a live component count.
    if (out_row < orows && out_col < ocols && comp_pos < comps) begin
      idx = out_col * comps + comp_pos;
      m   = window_max[idx];
      if ((row_in_win == 0 && col_in_win == 0) || s > m) m = s;
      window_max[idx] = m;
      if (row_in_win == wr - 1 && col_in_win == wc - 1) begin
        r.max_value     = m;
        r.last_of_image = (out_row == orows - 1 && out_col == ocols - 1 &&
                           comp_pos == comps - 1);
        r.last_of_batch = r.last_of_image && img_pos == nimg - 1;
        pooled_q.push_back(r);
      end
    end

    // Advance component, column, row and image; a counter past a lowered
    // limit wraps on its next advance.
    if (comp_pos + 1 >= comps) begin
      comp_pos = 0;
      if (col_in_win + 1 >= wc) begin
        col_in_win = 0;
        out_col++;
      end else begin
        col_in_win++;
      end
      if (col_pos + 1 >= cols) begin
        col_pos    = 0;
        col_in_win = 0;
        out_col    = 0;
        if (row_in_win + 1 >= wr) begin
          row_in_win = 0;
          out_row++;
        end else begin
          row_in_win++;
        end
        if (row_pos + 1 >= rows) begin
          row_pos    = 0;
          row_in_win = 0;
          out_row    = 0;
          img_pos    = (img_pos + 1 >= nimg) ? 0 : img_pos + 1;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    end else begin
      comp_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: hold tvalid until the transfer, then predict on it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) pool_sample(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest owed maximum,
  // and stall the output at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pooled_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pooled_q.size() == 0) begin
        $error("unexpected result: max_value %0d, last_of_image %0b, last_of_batch %0b",
               $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
        failures++;
      end else begin
        want = pooled_q.pop_front();
        if (m_axis_tdata !== want.max_value) begin
          $error("max_value: expected %0d, got %0d",
                 $signed(want.max_value), $signed(m_axis_tdata));
          failures++;
        end
        if (m_axis_tlast !== want.last_of_image) begin
          $error("last_of_image: expected %0b, got %0b", want.last_of_image, m_axis_tlast);
          failures++;
        end
        if (m_axis_tuser !== want.last_of_batch) begin
          $error("last_of_batch: expected %0b, got %0b", want.last_of_batch, m_axis_tuser);
          failures++;
        end
      end
    end
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Wait until every sample is in and every maximum is out, then let any
  // trailing samples that pool to nothing clear the pipe.
  task automatic settle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || pooled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    if (idx <= CFG_WINDOW_COLS) reg_shadow[idx] = value & reg_mask(idx);
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_shape(int unsigned nimg, int unsigned rows, int unsigned cols,
                           int unsigned comps, int unsigned wr, int unsigned wc);
    write_reg(CFG_IMAGE_COUNT, nimg);
    write_reg(CFG_IMAGE_ROWS, rows);
    write_reg(CFG_IMAGE_COLS, cols);
    write_reg(CFG_COMPONENT_COUNT, comps);
    write_reg(CFG_WINDOW_ROWS, wr);
    write_reg(CFG_WINDOW_COLS, wc);
    end_writes();
  endtask

  // Mostly full-range values; some extremes and a tight cluster around zero
  // so that ties and near-ties reach the comparator.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: case ($urandom_range(3))
           0: return 16'h8000;
           1: return 16'h7FFF;
           2: return 16'h0000;
           default: return 16'hFFFF;
         endcase
      1: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Feed whole images under the current shape.
  task automatic feed_images(int unsigned n, output int unsigned fed);
    fed = n * eff_reg(CFG_IMAGE_ROWS, MAX_ROWS) * eff_reg(CFG_IMAGE_COLS, MAX_COLS) *
          eff_reg(CFG_COMPONENT_COUNT, MAX_COMPONENTS);
    for (int unsigned i = 0; i < fed; i++) sample_q.push_back(pick_sample());
    settle();
  endtask

  // Sometimes write zero where one is meant; the block must read it as one.
  function automatic int unsigned maybe_zero(int unsigned v);
    return (v == 1 && $urandom_range(3) == 0) ? 0 : v;
  endfunction

  task automatic random_phase(output int unsigned fed);
    int unsigned wr, wc, comps, rows, cols;
    wr    = $urandom_range(1, 4);
    wc    = $urandom_range(1, 4);
    comps = ($urandom_range(7) == 0) ? 16 : $urandom_range(1, 3);
    if (comps == 16) begin
      rows = wr;
      cols = wc;
    end else begin
      rows = wr * $urandom_range(1, 2) + $urandom_range(0, wr - 1);
      cols = wc * $urandom_range(1, 2) + $urandom_range(0, wc - 1);
    end
    // Now and then a window taller than the image: nothing may come out.
    if ($urandom_range(9) == 0) begin
      wr   = $urandom_range(2, 4);
      rows = $urandom_range(1, wr - 1);
    end
    set_shape(maybe_zero($urandom_range(1, 4)), maybe_zero(rows), maybe_zero(cols),
              maybe_zero(comps), maybe_zero(wr), maybe_zero(wc));
    feed_images($urandom_range(1, 3), fed);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned fed, fed_total;
    foreach (reg_shadow[i]) reg_shadow[i] = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset shape is a 1x1 image, one component, 1x1 window: each sample
    // comes straight back, flagged as the end of image and batch.
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'hFFFF);
    settle();

    // Leave the stream in the middle of a pixel, then shrink the component
    // count: the stranded component is consumed without a result.
    write_reg(CFG_COMPONENT_COUNT, 4);
    end_writes();
    sample_q.push_back(16'h1234);
    sample_q.push_back(16'hFEDC);
    settle();
    write_reg(CFG_COMPONENT_COUNT, 0);
    write_reg(CFG_UNMAPPED_LO, 16'hFFFF);
    write_reg(CFG_UNMAPPED_HI, 16'h0000);
    end_writes();
    sample_q.push_back(16'h7FFF);
    sample_q.push_back(16'h8001);
    settle();

    // Two 2x2x2 images in 2x2 windows: one result per component per image.
    set_shape(2, 2, 2, 2, 2, 2);
    feed_images(2, fed);

    // Extreme shapes with random content.
    set_shape(65535, 32, 1, 1, 16, 1);
    feed_images(1, fed);
    // Lower the image count under a live image position: it wraps next image.
    // Run this widest image with no idling on either side.
    steady = 1'b1;
    set_shape(1, 1, 511, 1, 1, 16);
    feed_images(1, fed);
    steady = 1'b0;
    set_shape(1, 2, 2, 31, 2, 2);
    feed_images(1, fed);
    set_shape(2, 16, 4, 1, 16, 4);
    feed_images(1, fed);
    set_shape(1, 3, 4, 2, 31, 2);
    feed_images(2, fed);
    set_shape(0, 8, 2, 1, 4, 2);
    feed_images(1, fed);

    // Random shapes with random content.
    fed_total = 0;
    while (fed_total < RANDOM_ITEMS) begin
      random_phase(fed);
      fed_total += fed;
    end

    settle();
    if (failures == 0 && pooled_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* max_pool_2d_stream.f */
sv/mp2ds_pkg.sv
sv/mp2ds_front.sv
sv/mp2ds_queue.sv
sv/mp2ds_back.sv
sv/max_pool_2d_stream.sv
tb/sv/max_pool_2d_stream_test.sv
